// File: rtl/core/aarm_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared constants and types: arctangent table, pi, CORDIC gain, payload types.
// ----------------------------------------------------------------------------
package aarm_pkg;

	localparam int PHASE_W   = 34;
	localparam int MAX_STEPS = 24;
	localparam int ONE_Q14   = 16384;

	localparam logic signed [PHASE_W-1:0] PI_Q29      = 34'sd1686629713;
	localparam logic signed [PHASE_W-1:0] HALF_PI_Q29 = 34'sd843314856;
	localparam longint                    GAIN_Q30    = 652032874;

	localparam logic signed [PHASE_W-1:0] ATAN_Q29 [MAX_STEPS] = '{
		34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
		34'sd33510843,  34'sd16771758,  34'sd8387925,   34'sd4194219,
		34'sd2097141,   34'sd1048575,   34'sd524288,    34'sd262144,
		34'sd131072,    34'sd65536,     34'sd32768,     34'sd16384,
		34'sd8192,      34'sd4096,      34'sd2048,      34'sd1024,
		34'sd512,       34'sd256,       34'sd128,       34'sd64
	};

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} axis_t;

	typedef struct packed {
		logic signed [15:0] col0_x;
		logic signed [15:0] col0_y;
		logic signed [15:0] col0_z;
		logic signed [15:0] col1_x;
		logic signed [15:0] col1_y;
		logic signed [15:0] col1_z;
		logic signed [15:0] col2_x;
		logic signed [15:0] col2_y;
		logic signed [15:0] col2_z;
	} mat_t;

endpackage

// File: rtl/core/axis_angle_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// Axis-angle to rotation matrix
// Rodrigues' formula with CORDIC sine/cosine, fully pipelined.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    angle, axis_x, axis_y, axis_z
//   out      out_valid/out_ready  col0_x .. col2_z
//
// One beat enters per cycle unless a full stage further on is stalled.
// Depth is set by the CORDIC, one rotation per stage.
// Reset clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled; bubbles fill.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] col0_x,
	output logic signed [15:0] col0_y,
	output logic signed [15:0] col0_z,
	output logic signed [15:0] col1_x,
	output logic signed [15:0] col1_y,
	output logic signed [15:0] col1_z,
	output logic signed [15:0] col2_x,
	output logic signed [15:0] col2_y,
	output logic signed [15:0] col2_z
);

	axis_t              axis_in, axis_cs;
	logic               cs_valid, cs_ready;
	logic signed [15:0] cos_v, sin_v;
	mat_t               mat;

	assign axis_in.x = axis_x;
	assign axis_in.y = axis_y;
	assign axis_in.z = axis_z;

	aarm_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.FRAC_BITS   (FRAC_BITS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.angle    (angle),
		.axis_in  (axis_in),
		.out_valid(cs_valid),
		.out_ready(cs_ready),
		.cos_out  (cos_v),
		.sin_out  (sin_v),
		.axis_out (axis_cs)
	);

	aarm_mat u_mat (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cs_valid),
		.in_ready (cs_ready),
		.cos_in   (cos_v),
		.sin_in   (sin_v),
		.axis_in  (axis_cs),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mat      (mat)
	);

	assign col0_x = mat.col0_x;
	assign col0_y = mat.col0_y;
	assign col0_z = mat.col0_z;
	assign col1_x = mat.col1_x;
	assign col1_y = mat.col1_y;
	assign col1_z = mat.col1_z;
	assign col2_x = mat.col2_x;
	assign col2_y = mat.col2_y;
	assign col2_z = mat.col2_z;

endmodule

// File: rtl/core/aarm_cordic.sv
// ----------------------------------------------------------------------------
// Sine/cosine CORDIC pipeline
// Negates and range-reduces the angle, runs one rotation per stage and rounds
// the results to saturated Q1.14.
// ----------------------------------------------------------------------------
module aarm_cordic import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] angle,
	input  axis_t              axis_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] cos_out,
	output logic signed [15:0] sin_out,
	output axis_t              axis_out
);

	localparam int N     = CORDIC_STEPS;
	localparam int XW    = FRAC_BITS + 3;
	localparam int CW    = XW + 16;
	localparam int PW    = PHASE_W;
	localparam int SHR   = (FRAC_BITS >= 14) ? (FRAC_BITS - 14) : 0;
	localparam int SHL   = (FRAC_BITS < 14) ? (14 - FRAC_BITS) : 0;
	localparam int GSH   = 30 - FRAC_BITS;
	localparam longint GAIN_INIT = (GSH > 0) ?
		((GAIN_Q30 + ((64'sd1 << GSH) >>> 1)) >>> GSH) : GAIN_Q30;

	logic [N+1:0] v_s;
	logic [N+1:0] en;

	logic signed [XW-1:0] x_s  [N+1];
	logic signed [XW-1:0] y_s  [N+1];
	logic signed [PW-1:0] ph_s [N+1];
	logic                 flip_s [N+1];
	axis_t                ax_s [N+1];

	logic signed [15:0] cos_sc, sin_sc;
	axis_t              ax_sc;

	logic signed [17:0]   neg_ang;
	logic signed [PW-1:0] phi;
	logic signed [PW-1:0] phi_red;
	logic                 flip;
	logic signed [XW-1:0] cx, sy;

	function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
		logic signed [CW-1:0] w;
		w = ((CW'(v) + ((CW'(1) <<< SHR) >>> 1)) >>> SHR) <<< SHL;
		if (w > CW'(ONE_Q14))
			return 16'(ONE_Q14);
		else if (w < -CW'(ONE_Q14))
			return -16'(ONE_Q14);
		else
			return w[15:0];
	endfunction

	always_comb begin
		en[N+1] = !v_s[N+1] || out_ready;
		for (int k = N; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0])
				v_s[0] <= in_valid;
			for (int k = 1; k <= N + 1; k++) begin
				if (en[k])
					v_s[k] <= v_s[k-1];
			end
		end
	end

	always_comb begin
		neg_ang = -18'(angle);
		phi     = {neg_ang, 16'b0};
		flip    = 1'b0;
		phi_red = phi;
		if (phi > HALF_PI_Q29) begin
			phi_red = phi - PI_Q29;
			flip    = 1'b1;
		end else if (phi < -HALF_PI_Q29) begin
			phi_red = phi + PI_Q29;
			flip    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s[0]    <= XW'(GAIN_INIT);
			y_s[0]    <= '0;
			ph_s[0]   <= phi_red;
			flip_s[0] <= flip;
			ax_s[0]   <= axis_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [XW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				if (!ph_s[i][PW-1]) begin
					x_s[i+1]  <= x_s[i] - dx;
					y_s[i+1]  <= y_s[i] + dy;
					ph_s[i+1] <= ph_s[i] - ATAN_Q29[i];
				end else begin
					x_s[i+1]  <= x_s[i] + dx;
					y_s[i+1]  <= y_s[i] - dy;
					ph_s[i+1] <= ph_s[i] + ATAN_Q29[i];
				end
				flip_s[i+1] <= flip_s[i];
				ax_s[i+1]   <= ax_s[i];
			end
		end
	end

	assign cx = flip_s[N] ? -x_s[N] : x_s[N];
	assign sy = flip_s[N] ? -y_s[N] : y_s[N];

	always_ff @(posedge clk) begin
		if (en[N+1]) begin
			cos_sc <= to_q14(cx);
			sin_sc <= to_q14(sy);
			ax_sc  <= ax_s[N];
		end
	end

	assign out_valid = v_s[N+1];
	assign cos_out   = cos_sc;
	assign sin_out   = sin_sc;
	assign axis_out  = ax_sc;

endmodule

// File: rtl/core/aarm_mat.sv
// ----------------------------------------------------------------------------
// Rodrigues matrix pipeline
// Forms the nine entries from sine, cosine and axis in four register stages,
// rounding once to saturated Q1.14.
// ----------------------------------------------------------------------------
module aarm_mat import aarm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] cos_in,
	input  logic signed [15:0] sin_in,
	input  axis_t              axis_in,
	output logic               out_valid,
	input  logic               out_ready,
	output mat_t               mat
);

	localparam int SW = 50;

	logic [3:0] v_s;
	logic [3:0] en;

	logic signed [16:0] omc_s1;
	logic signed [31:0] p_s1 [6];
	logic signed [31:0] q_s1 [3];
	logic signed [15:0] c_s1;

	logic signed [48:0] m_s2 [6];
	logic signed [31:0] q_s2 [3];
	logic signed [15:0] c_s2;

	logic signed [SW-1:0] sum_s3 [9];
	logic signed [15:0]   r_s4 [9];

	logic signed [SW-1:0] cterm, rnd;
	logic signed [SW-1:0] xs, ys, zs;

	function automatic logic signed [15:0] sat_q14(input logic signed [SW-1:0] v);
		logic signed [21:0] r;
		r = v[SW-1:28];
		if (r > 22'(ONE_Q14))
			return 16'(ONE_Q14);
		else if (r < -22'(ONE_Q14))
			return -16'(ONE_Q14);
		else
			return r[15:0];
	endfunction

	always_comb begin
		en[3] = !v_s[3] || out_ready;
		en[2] = !v_s[2] || en[3];
		en[1] = !v_s[1] || en[2];
		en[0] = !v_s[0] || en[1];
	end

	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			if (en[1]) v_s[1] <= v_s[0];
			if (en[2]) v_s[2] <= v_s[1];
			if (en[3]) v_s[3] <= v_s[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			omc_s1  <= 17'(ONE_Q14) - 17'(cos_in);
			p_s1[0] <= 32'(axis_in.x) * 32'(axis_in.x);
			p_s1[1] <= 32'(axis_in.y) * 32'(axis_in.y);
			p_s1[2] <= 32'(axis_in.z) * 32'(axis_in.z);
			p_s1[3] <= 32'(axis_in.x) * 32'(axis_in.y);
			p_s1[4] <= 32'(axis_in.x) * 32'(axis_in.z);
			p_s1[5] <= 32'(axis_in.y) * 32'(axis_in.z);
			q_s1[0] <= 32'(axis_in.x) * 32'(sin_in);
			q_s1[1] <= 32'(axis_in.y) * 32'(sin_in);
			q_s1[2] <= 32'(axis_in.z) * 32'(sin_in);
			c_s1    <= cos_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 6; k++) begin
				m_s2[k] <= 49'(p_s1[k]) * 49'(omc_s1);
			end
			for (int k = 0; k < 3; k++) begin
				q_s2[k] <= q_s1[k];
			end
			c_s2 <= c_s1;
		end
	end

	always_comb begin
		rnd   = SW'(1) <<< 27;
		cterm = (SW'(c_s2) <<< 28) + rnd;
		xs    = SW'(q_s2[0]) <<< 14;
		ys    = SW'(q_s2[1]) <<< 14;
		zs    = SW'(q_s2[2]) <<< 14;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sum_s3[0] <= SW'(m_s2[0]) + cterm;
			sum_s3[1] <= SW'(m_s2[3]) - zs + rnd;
			sum_s3[2] <= SW'(m_s2[4]) + ys + rnd;
			sum_s3[3] <= SW'(m_s2[3]) + zs + rnd;
			sum_s3[4] <= SW'(m_s2[1]) + cterm;
			sum_s3[5] <= SW'(m_s2[5]) - xs + rnd;
			sum_s3[6] <= SW'(m_s2[4]) - ys + rnd;
			sum_s3[7] <= SW'(m_s2[5]) + xs + rnd;
			sum_s3[8] <= SW'(m_s2[2]) + cterm;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int k = 0; k < 9; k++) begin
				r_s4[k] <= sat_q14(sum_s3[k]);
			end
		end
	end

	assign out_valid  = v_s[3];
	assign mat.col0_x = r_s4[0];
	assign mat.col0_y = r_s4[1];
	assign mat.col0_z = r_s4[2];
	assign mat.col1_x = r_s4[3];
	assign mat.col1_y = r_s4[4];
	assign mat.col1_z = r_s4[5];
	assign mat.col2_x = r_s4[6];
	assign mat.col2_y = r_s4[7];
	assign mat.col2_z = r_s4[8];

endmodule

// File: test/axis_angle_rotation_matrix_checker.sv
// ----------------------------------------------------------------------------
// Rotation matrix checker
// Watches both channels, predicts each matrix from the accepted angle and axis
// with a CORDIC sine/cosine and Rodrigues' formula, and compares every field.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_checker import aarm_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  mat_t               mat,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	mat_t matrices_due[$];

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > ONE_Q14) return ONE_Q14;
		if (v < -ONE_Q14) return -ONE_Q14;
		return v;
	endfunction

	function automatic longint scale_q14(longint v);
		int sh;
		sh = FRAC_BITS - 14;
		if (sh == 0) return v;
		if (sh > 0) return asr(v + (longint'(1) <<< (sh - 1)), sh);
		return v * (longint'(1) <<< (-sh));
	endfunction

	function automatic logic signed [15:0] round_entry(longint v);
		return 16'(clamp_unit(asr(v + (longint'(1) <<< 27), 28)));
	endfunction

	function automatic mat_t rotation_matrix(logic signed [15:0] ang,
			logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az);
		longint phi, gx, gy, dx, dy, c, s, omc, x, y, z, sc2;
		int gsh;
		bit flip;
		mat_t m;
		flip = 0;
		phi = -longint'(ang) * (longint'(1) <<< 16);
		if (phi > HALF_PI_Q29) begin
			phi -= PI_Q29;
			flip = 1;
		end else if (phi < -longint'(HALF_PI_Q29)) begin
			phi += PI_Q29;
			flip = 1;
		end
		gsh = 30 - FRAC_BITS;
		gx = GAIN_Q30;
		if (gsh > 0) gx = (gx + (longint'(1) <<< (gsh - 1))) >>> gsh;
		gy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = asr(gy, i);
			dy = asr(gx, i);
			if (phi >= 0) begin
				gx -= dx;
				gy += dy;
				phi -= ATAN_Q29[i];
			end else begin
				gx += dx;
				gy -= dy;
				phi += ATAN_Q29[i];
			end
		end
		if (flip) begin
			gx = -gx;
			gy = -gy;
		end
		c = clamp_unit(scale_q14(gx));
		s = clamp_unit(scale_q14(gy));
		omc = ONE_Q14 - c;
		sc2 = longint'(1) <<< 28;
		x = ax;
		y = ay;
		z = az;
		m.col0_x = round_entry(x * x * omc + c * sc2);
		m.col0_y = round_entry(x * y * omc - z * s * 16384);
		m.col0_z = round_entry(x * z * omc + y * s * 16384);
		m.col1_x = round_entry(y * x * omc + z * s * 16384);
		m.col1_y = round_entry(y * y * omc + c * sc2);
		m.col1_z = round_entry(y * z * omc - x * s * 16384);
		m.col2_x = round_entry(z * x * omc - y * s * 16384);
		m.col2_y = round_entry(z * y * omc + x * s * 16384);
		m.col2_z = round_entry(z * z * omc + c * sc2);
		return m;
	endfunction

	task automatic compare_field(string name, logic signed [15:0] want, logic signed [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	initial errors = 0;
	assign pending = matrices_due.size();

	always @(posedge clk) begin
		mat_t want;
		if (arst_n && in_valid && in_ready)
			matrices_due.push_back(rotation_matrix(angle, axis_x, axis_y, axis_z));
		if (arst_n && out_valid && out_ready) begin
			if (matrices_due.size() == 0) begin
				$error("matrix beat with none expected");
				errors++;
			end else begin
				want = matrices_due.pop_front();
				compare_field("col0_x", want.col0_x, mat.col0_x);
				compare_field("col0_y", want.col0_y, mat.col0_y);
				compare_field("col0_z", want.col0_z, mat.col0_z);
				compare_field("col1_x", want.col1_x, mat.col1_x);
				compare_field("col1_y", want.col1_y, mat.col1_y);
				compare_field("col1_z", want.col1_z, mat.col1_z);
				compare_field("col2_x", want.col2_x, mat.col2_x);
				compare_field("col2_y", want.col2_y, mat.col2_y);
				compare_field("col2_z", want.col2_z, mat.col2_z);
			end
		end
	end
endmodule

// File: test/axis_angle_rotation_matrix_top_tb.sv
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix testbench
// Drives directed and random angle/axis beats in bursts, stalls the matrix
// side on its own pattern with one long hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top_tb;
	import aarm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS  = 16;
	localparam int LAT    = STEPS + 6;
	localparam int N_RAND = 1600;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_ready = 0, in_ready, out_valid;
	logic signed [15:0] angle = 0, axis_x = 0, axis_y = 0, axis_z = 0;
	mat_t mat;
	int errors, pending;
	bit hold_off = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	axis_angle_rotation_matrix_top #(.CORDIC_STEPS(STEPS), .FRAC_BITS(14)) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.col0_x(mat.col0_x), .col0_y(mat.col0_y), .col0_z(mat.col0_z),
		.col1_x(mat.col1_x), .col1_y(mat.col1_y), .col1_z(mat.col1_z),
		.col2_x(mat.col2_x), .col2_y(mat.col2_y), .col2_z(mat.col2_z)
	);

	axis_angle_rotation_matrix_checker #(.CORDIC_STEPS(STEPS), .FRAC_BITS(14)) chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_ready(out_ready), .mat(mat),
		.errors(errors), .pending(pending)
	);

	task automatic send_beat(logic signed [15:0] a, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		in_valid <= 1;
		angle    <= a;
		axis_x   <= x;
		axis_y   <= y;
		axis_z   <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic signed [15:0] axis_value();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	always @(posedge clk) begin
		if (hold_off) out_ready <= 0;
		else case ($urandom_range(0, 3))
			0: out_ready <= ($urandom_range(0, 3) != 0);
			1: out_ready <= 1;
			default: out_ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	initial begin
		repeat (100) @(posedge clk);
		hold_off = 1;
		repeat (3 * LAT) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int gap, burst;
		logic signed [15:0] angles [8] = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd12868,
			-16'sd12868, 16'sd25736, -16'sd25736, 16'sd1};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (angles[i]) send_beat(angles[i], 16'sd16384, 16'sd0, 16'sd0);
		send_beat(16'sd6434, 16'sd0, 16'sd0, 16'sd16384);
		send_beat(16'sd6434, 16'sd0, -16'sd16384, 16'sd0);
		send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_beat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_beat(-16'sd9000, 16'sd9459, 16'sd9459, 16'sd9459);
		send_beat(16'sd3000, 16'sh8000, 16'sh7FFF, 16'sd0);
		for (int n = 0; n < N_RAND; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < N_RAND; b++, n++)
				send_beat(16'($urandom), axis_value(), axis_value(), axis_value());
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: files.f
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic.sv
rtl/core/aarm_mat.sv
rtl/core/axis_angle_rotation_matrix_top.sv
test/axis_angle_rotation_matrix_checker.sv
test/axis_angle_rotation_matrix_top_tb.sv
